[design/text_encoding_detector_defines.svh]
// Assertion macros shared by the text encoding detector RTL.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef TEXT_ENCODING_DETECTOR_DEFINES_SVH
`define TEXT_ENCODING_DETECTOR_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define TED_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition in one cycle that implies another in the following cycle.
`define TED_ASSERT_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error(msg);

`endif

[design/tedt_pkg.sv]
// Shared types, constants and the byte classifier of the text encoding detector.
// Has no dependencies; the front, queue, back end and top files refer to it by scoped names.
package tedt_pkg;

	localparam int PCT_W = 7;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PCT_HIGH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PCT_LOW = 1'b1;

	localparam logic [PCT_W-1:0] PCT_HIGH_RST = 7'd70;
	localparam logic [PCT_W-1:0] PCT_LOW_RST = 7'd50;
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	// Verdict codes.
	localparam logic [1:0] VERDICT_NONE = 2'd0;
	localparam logic [1:0] VERDICT_ISO = 2'd1;
	localparam logic [1:0] VERDICT_EBCDIC = 2'd2;

	// Byte values with a special meaning.
	localparam logic [7:0] BYTE_TAB = 8'h09;
	localparam logic [7:0] BYTE_LF = 8'h0A;
	localparam logic [7:0] BYTE_E_NL = 8'h15;
	localparam logic [7:0] BYTE_E_HT = 8'h05;
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] BYTE_DEL = 8'h7F;
	localparam logic [7:0] BYTE_E_SPACE = 8'h40;
	localparam logic [7:0] BYTE_E_LBRACK = 8'hAD;
	localparam logic [7:0] BYTE_E_RBRACK = 8'hBD;

	typedef struct packed {
		logic ascii;
		logic ebcdic;
		logic ctrl;
	} class_t;

	typedef struct packed {
		logic [PCT_W-1:0] high;
		logic [PCT_W-1:0] low;
	} thresh_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic in_span(input logic [7:0] b, input logic [7:0] lo,
			input logic [7:0] hi);
		return (b >= lo) && (b <= hi);
	endfunction

	function automatic logic is_ebcdic_text(input logic [7:0] b);
		return (b == BYTE_E_SPACE) || (b == BYTE_E_LBRACK) || (b == BYTE_E_RBRACK) ||
			in_span(b, 8'h4B, 8'h50) || in_span(b, 8'h5A, 8'h61) ||
			in_span(b, 8'h6A, 8'h6F) || in_span(b, 8'h79, 8'h7F) ||
			in_span(b, 8'h81, 8'h8B) || in_span(b, 8'h91, 8'h99) ||
			in_span(b, 8'hA1, 8'hA9) || in_span(b, 8'hC0, 8'hC9) ||
			in_span(b, 8'hD0, 8'hD9) || in_span(b, 8'hE0, 8'hE9) ||
			in_span(b, 8'hF0, 8'hF9);
	endfunction

	function automatic class_t classify(input logic [7:0] b);
		class_t c;
		c = '0;
		if ((b == BYTE_E_NL) || (b == BYTE_E_HT)) begin
			c.ebcdic = 1'b1;
		end else if ((b == BYTE_LF) || (b == BYTE_TAB)) begin
			c.ascii = 1'b1;
		end else if (b < BYTE_SPACE) begin
			c.ctrl = 1'b1;
		end else begin
			c.ascii = (b < BYTE_DEL);
			c.ebcdic = is_ebcdic_text(b);
		end
		return c;
	endfunction

endpackage

[design/tedt_if.sv]
// Valid/ready channel interfaces of the text encoding detector.
// Depends on nothing; widths are the fixed field widths of the channels.
interface tedt_sample_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface tedt_result_if;
	logic valid;
	logic ready;
	logic [1:0] verdict;
	logic [6:0] ascii_share;
	logic [6:0] ebcdic_share;
	logic binary_seen;

	modport source(output valid, output verdict, output ascii_share,
		output ebcdic_share, output binary_seen, input ready);
	modport sink(input valid, input verdict, input ascii_share,
		input ebcdic_share, input binary_seen, output ready);
endinterface

[design/text_encoding_detector.sv]
// Top level of the text encoding detector: front end, job queue, back end.
// Depends on tedt_pkg, tedt_if, tedt_front, tedt_fifo, tedt_back and the defines header.

// The detector takes one byte per transfer on the sample channel and counts
// the first SAMPLE_BYTES bytes of each sample as ASCII, EBCDIC, both or
// neither; a stray control byte sets a sticky binary flag. The transfer that
// carries last_byte ends the sample and hands its counts to a two-entry job
// queue, and the counters start afresh on the next cycle. For each job the
// back end loads the counts scaled by 100, runs seven steps of a shared
// restoring divider (one quotient bit of both percentages per step), and
// forms the verdict into the output register, which then waits for its
// transfer on the result channel. Long samples thus stream at one byte per
// cycle while the queue has room; the front end takes new samples while the
// back end works, until the queue is full and the sample channel drops ready.
// The user must write thresholds through the cfg port (index 0 pct_high,
// index 1 pct_low) while no sample is in flight; the block does not enforce it.
`include "text_encoding_detector_defines.svh"

module text_encoding_detector #(
	parameter int SAMPLE_BYTES = 256
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [tedt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [tedt_pkg::PCT_W-1:0] cfg_wdata,
	tedt_sample_if.sink sample,
	tedt_result_if.source result
);

	// The counters must hold SAMPLE_BYTES itself.
	localparam int CW = $clog2(SAMPLE_BYTES + 1);
	localparam int JW = 3 * CW + 1;
	localparam int QDEPTH = 2;

	tedt_pkg::thresh_t thresh_q;
	tedt_pkg::fifo_stat_t job_stat;
	logic job_push;
	logic job_pop;
	logic [JW-1:0] job_wdata;
	logic [JW-1:0] job_rdata;

	// Threshold registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q.high <= tedt_pkg::PCT_HIGH_RST;
			thresh_q.low <= tedt_pkg::PCT_LOW_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				tedt_pkg::REG_PCT_HIGH: thresh_q.high <= cfg_wdata;
				tedt_pkg::REG_PCT_LOW: thresh_q.low <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// The front end classifies and counts; it stalls only when the queue is full.
	tedt_front #(
		.SAMPLE_BYTES(SAMPLE_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.job_full(job_stat.full),
		.job_push(job_push),
		.job_data(job_wdata)
	);

	tedt_fifo #(
		.WIDTH(JW),
		.DEPTH(QDEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.wdata(job_wdata),
		.pop(job_pop),
		.rdata(job_rdata),
		.stat(job_stat)
	);

	// The back end divides, forms the verdict and owns the result register.
	tedt_back #(
		.SAMPLE_BYTES(SAMPLE_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.thresh(thresh_q),
		.job_stat(job_stat),
		.job_data(job_rdata),
		.job_pop(job_pop),
		.result(result)
	);

	// A finished sample must never meet a full queue, or its verdict is lost.
	`TED_ASSERT(a_no_job_overflow, !(job_push && job_stat.full), "job queue overflow")
	// A popped job must come from a non-empty queue.
	`TED_ASSERT(a_no_job_underflow, !(job_pop && job_stat.empty), "job queue underflow")
	// Floor percentages of counts bounded by the sample size stay within 100.
	`TED_ASSERT(a_share_range, !result.valid || ((result.ascii_share <= tedt_pkg::PCT_FULL) && (result.ebcdic_share <= tedt_pkg::PCT_FULL)), "share above 100 percent")
	// A binary sample always reports the untagged verdict.
	`TED_ASSERT(a_binary_untagged, !(result.valid && result.binary_seen) || (result.verdict == tedt_pkg::VERDICT_NONE), "binary sample with a text verdict")

endmodule

[design/tedt_front.sv]
// Front end: takes sample bytes, classifies and counts them, and on the
// last byte pushes the finished counts as one job. Uses tedt_pkg and tedt_if.
module tedt_front #(
	parameter int SAMPLE_BYTES = 256
) (
	input logic clk,
	input logic arst_n,
	tedt_sample_if.sink sample,
	input logic job_full,
	output logic job_push,
	output logic [3*$clog2(SAMPLE_BYTES+1):0] job_data
);

	localparam int CW = $clog2(SAMPLE_BYTES + 1);

	logic [CW-1:0] ascii_q;
	logic [CW-1:0] ebcdic_q;
	logic [CW-1:0] sampled_q;
	logic ctrl_q;

	tedt_pkg::class_t cls;
	logic take;
	logic accept;
	logic [CW-1:0] ascii_nx;
	logic [CW-1:0] ebcdic_nx;
	logic [CW-1:0] sampled_nx;
	logic ctrl_nx;

	assign sample.ready = !job_full;
	assign accept = sample.valid && sample.ready;

	always_comb begin
		cls = tedt_pkg::classify(sample.data_byte);
		take = (sampled_q < CW'(SAMPLE_BYTES));
		ascii_nx = ascii_q + CW'(take && cls.ascii);
		ebcdic_nx = ebcdic_q + CW'(take && cls.ebcdic);
		sampled_nx = sampled_q + CW'(take);
		ctrl_nx = ctrl_q || (take && cls.ctrl);
	end

	assign job_push = accept && sample.last_byte;
	assign job_data = {ascii_nx, ebcdic_nx, sampled_nx, ctrl_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ascii_q <= '0;
			ebcdic_q <= '0;
			sampled_q <= '0;
			ctrl_q <= 1'b0;
		end else if (accept) begin
			if (sample.last_byte) begin
				ascii_q <= '0;
				ebcdic_q <= '0;
				sampled_q <= '0;
				ctrl_q <= 1'b0;
			end else begin
				ascii_q <= ascii_nx;
				ebcdic_q <= ebcdic_nx;
				sampled_q <= sampled_nx;
				ctrl_q <= ctrl_nx;
			end
		end
	end

endmodule

[design/tedt_fifo.sv]
// Small job queue between the front and back ends of the detector.
// Uses tedt_pkg for the status struct.
module tedt_fifo #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] wdata,
	input logic pop,
	output logic [WIDTH-1:0] rdata,
	output tedt_pkg::fifo_stat_t stat
);

	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign stat.full = (count_q == NW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/tedt_back.sv]
// Back end: turns a job of counts into two floor percentages with a shared
// restoring divider sequence, forms the verdict and holds it in the output
// register. Uses tedt_pkg and tedt_if.
module tedt_back #(
	parameter int SAMPLE_BYTES = 256
) (
	input logic clk,
	input logic arst_n,
	input tedt_pkg::thresh_t thresh,
	input tedt_pkg::fifo_stat_t job_stat,
	input logic [3*$clog2(SAMPLE_BYTES+1):0] job_data,
	output logic job_pop,
	tedt_result_if.source result
);

	localparam int CW = $clog2(SAMPLE_BYTES + 1);
	localparam int PW = tedt_pkg::PCT_W;
	localparam int DW = CW + PW;
	localparam int SW = $clog2(PW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0] state_q;
	logic [SW-1:0] step_q;
	logic [DW-1:0] rem_a_q;
	logic [DW-1:0] rem_e_q;
	logic [CW-1:0] total_q;
	logic ctrl_q;
	logic [PW-1:0] quo_a_q;
	logic [PW-1:0] quo_e_q;

	logic out_valid_q;
	logic [1:0] verdict_q;
	logic [PW-1:0] ascii_share_q;
	logic [PW-1:0] ebcdic_share_q;
	logic binary_q;

	logic [CW-1:0] job_ascii;
	logic [CW-1:0] job_ebcdic;
	logic [CW-1:0] job_total;
	logic job_ctrl;
	logic [DW-1:0] div_shift;
	logic bit_a;
	logic bit_e;
	logic out_free;
	logic out_load;
	logic [1:0] verdict_nx;

	assign {job_ascii, job_ebcdic, job_total, job_ctrl} = job_data;

	assign job_pop = (state_q == ST_IDLE) && !job_stat.empty;
	assign out_free = !out_valid_q || result.ready;
	assign out_load = (state_q == ST_HOLD) && out_free;

	// Quotient bit step_q of part*100/total; remainder stays below total << (step_q+1).
	always_comb begin
		div_shift = DW'(total_q) << step_q;
		bit_a = (total_q != '0) && (rem_a_q >= div_shift);
		bit_e = (total_q != '0) && (rem_e_q >= div_shift);
	end

	always_comb begin
		verdict_nx = tedt_pkg::VERDICT_NONE;
		if (ctrl_q) begin
			verdict_nx = tedt_pkg::VERDICT_NONE;
		end else if ((quo_a_q > thresh.high) && (quo_e_q > thresh.high)) begin
			verdict_nx = tedt_pkg::VERDICT_NONE;
		end else if ((quo_a_q > thresh.high) && (quo_e_q < thresh.low)) begin
			verdict_nx = tedt_pkg::VERDICT_ISO;
		end else if ((quo_e_q > thresh.high) && (quo_a_q < thresh.low)) begin
			verdict_nx = tedt_pkg::VERDICT_EBCDIC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_pop) begin
						state_q <= ST_DIV;
						step_q <= SW'(PW - 1);
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_HOLD;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			rem_a_q <= DW'(job_ascii) * DW'(tedt_pkg::PCT_FULL);
			rem_e_q <= DW'(job_ebcdic) * DW'(tedt_pkg::PCT_FULL);
			total_q <= job_total;
			ctrl_q <= job_ctrl;
			quo_a_q <= '0;
			quo_e_q <= '0;
		end else if (state_q == ST_DIV) begin
			if (bit_a) begin
				rem_a_q <= rem_a_q - div_shift;
			end
			if (bit_e) begin
				rem_e_q <= rem_e_q - div_shift;
			end
			quo_a_q[step_q] <= bit_a;
			quo_e_q[step_q] <= bit_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			verdict_q <= verdict_nx;
			ascii_share_q <= quo_a_q;
			ebcdic_share_q <= quo_e_q;
			binary_q <= ctrl_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.verdict = verdict_q;
	assign result.ascii_share = ascii_share_q;
	assign result.ebcdic_share = ebcdic_share_q;
	assign result.binary_seen = binary_q;

endmodule

[verif/text_encoding_checker.sv]
`timescale 1ns / 100ps
// Scoreboard of the text encoding detector: tracks thresholds and byte tallies per sample.
// Depends on tedt_pkg and on the channel interfaces of tedt_if.sv.
module text_encoding_checker #(
	parameter int SAMPLE_BYTES = 256
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [tedt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [tedt_pkg::PCT_W-1:0] cfg_wdata,
	tedt_sample_if smp,
	tedt_result_if res,
	output int fail_count,
	output int outstanding,
	output int reports_checked,
	output int none_verdicts,
	output int iso_verdicts,
	output int ebcdic_verdicts
);
	import tedt_pkg::*;

	localparam int TALLY_W = $clog2(SAMPLE_BYTES + 1);
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [1:0] verdict;
		logic [PCT_W-1:0] ascii_share;
		logic [PCT_W-1:0] ebcdic_share;
		logic binary_seen;
	} share_report_t;

	share_report_t expected_reports[$];
	logic [PCT_W-1:0] high_pct;
	logic [PCT_W-1:0] low_pct;
	logic [TALLY_W-1:0] ascii_tally;
	logic [TALLY_W-1:0] ebcdic_tally;
	logic [TALLY_W-1:0] taken_tally;
	logic stray_control;
	int mismatches;
	int checked;
	int tally_none;
	int tally_iso;
	int tally_ebcdic;

	function automatic logic counts_as_ascii(input logic [7:0] b);
		return (b == BYTE_TAB) || (b == BYTE_LF) || ((b >= BYTE_SPACE) && (b < BYTE_DEL));
	endfunction

	function automatic logic counts_as_ebcdic(input logic [7:0] b);
		case (b) inside
			BYTE_E_NL, BYTE_E_HT, BYTE_E_SPACE, BYTE_E_LBRACK, BYTE_E_RBRACK,
			[8'h4B:8'h50], [8'h5A:8'h61], [8'h6A:8'h6F], [8'h79:8'h7F],
			[8'h81:8'h8B], [8'h91:8'h99], [8'hA1:8'hA9], [8'hC0:8'hC9],
			[8'hD0:8'hD9], [8'hE0:8'hE9], [8'hF0:8'hF9]: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Internal state is updated with blocking assignments and only read here;
	// the outputs are copied out with nonblocking ones at the end of each edge.
	always @(posedge clk or negedge arst_n) begin : track
		int a_pct;
		int e_pct;
		share_report_t want;
		share_report_t got;
		if (!arst_n) begin
			high_pct = PCT_HIGH_RST;
			low_pct = PCT_LOW_RST;
			ascii_tally = '0;
			ebcdic_tally = '0;
			taken_tally = '0;
			stray_control = 1'b0;
			expected_reports.delete();
			mismatches = 0;
			checked = 0;
			tally_none = 0;
			tally_iso = 0;
			tally_ebcdic = 0;
		end else begin
			if (cfg_wen) begin
				if (cfg_idx == REG_PCT_HIGH) begin
					high_pct = cfg_wdata;
				end else if (cfg_idx == REG_PCT_LOW) begin
					low_pct = cfg_wdata;
				end
			end
			if (smp.valid && smp.ready) begin
				if (taken_tally < SAMPLE_BYTES) begin
					taken_tally++;
					if (counts_as_ascii(smp.data_byte)) begin
						ascii_tally++;
					end
					if (counts_as_ebcdic(smp.data_byte)) begin
						ebcdic_tally++;
					end
					if ((smp.data_byte < BYTE_SPACE) && !counts_as_ascii(smp.data_byte) &&
							!counts_as_ebcdic(smp.data_byte)) begin
						stray_control = 1'b1;
					end
				end
				if (smp.last_byte) begin
					a_pct = 0;
					e_pct = 0;
					if (taken_tally != 0) begin
						a_pct = int'(ascii_tally) * int'(PCT_FULL) / int'(taken_tally);
						e_pct = int'(ebcdic_tally) * int'(PCT_FULL) / int'(taken_tally);
					end
					want.ascii_share = a_pct[PCT_W-1:0];
					want.ebcdic_share = e_pct[PCT_W-1:0];
					want.binary_seen = stray_control;
					if (stray_control) begin
						want.verdict = VERDICT_NONE;
					end else if ((a_pct > high_pct) && (e_pct > high_pct)) begin
						want.verdict = VERDICT_NONE;
					end else if ((a_pct > high_pct) && (e_pct < low_pct)) begin
						want.verdict = VERDICT_ISO;
					end else if ((e_pct > high_pct) && (a_pct < low_pct)) begin
						want.verdict = VERDICT_EBCDIC;
					end else begin
						want.verdict = VERDICT_NONE;
					end
					expected_reports.push_back(want);
					ascii_tally = '0;
					ebcdic_tally = '0;
					taken_tally = '0;
					stray_control = 1'b0;
				end
			end
			if (res.valid && res.ready) begin
				got.verdict = res.verdict;
				got.ascii_share = res.ascii_share;
				got.ebcdic_share = res.ebcdic_share;
				got.binary_seen = res.binary_seen;
				checked++;
				case (got.verdict)
					VERDICT_ISO: tally_iso++;
					VERDICT_EBCDIC: tally_ebcdic++;
					default: tally_none++;
				endcase
				if (expected_reports.size() == 0) begin
					if (mismatches < REPORT_LIMIT) begin
						$display("%0t: report with no sample waiting: verdict %0d ascii %0d ebcdic %0d binary %0b",
							$time, got.verdict, got.ascii_share, got.ebcdic_share,
							got.binary_seen);
					end
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					if (got != want) begin
						if (mismatches < REPORT_LIMIT) begin
							$display("%0t: report mismatch: expected verdict %0d ascii %0d ebcdic %0d binary %0b, got verdict %0d ascii %0d ebcdic %0d binary %0b",
								$time, want.verdict, want.ascii_share, want.ebcdic_share,
								want.binary_seen, got.verdict, got.ascii_share,
								got.ebcdic_share, got.binary_seen);
						end
						mismatches++;
					end
				end
			end
		end
		fail_count <= mismatches;
		outstanding <= expected_reports.size();
		reports_checked <= checked;
		none_verdicts <= tally_none;
		iso_verdicts <= tally_iso;
		ebcdic_verdicts <= tally_ebcdic;
	end

endmodule

[verif/tb_text_encoding_detector.sv]
`timescale 1ns / 100ps
// Testbench top of the text encoding detector: clock, reset, stimulus and verdict.
// Depends on tedt_pkg, tedt_if.sv, the detector RTL and text_encoding_checker.
module tb_text_encoding_detector;
	import tedt_pkg::*;

	localparam int SAMPLE_BYTES = 256;
	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 10;
	// Cycles without any transfer on either channel before the run is declared hung.
	// The slowest legal gap is a receiver stall on top of a back end job.
	localparam int STALL_LIMIT = 5000;
	// The back end works on one job at a time, and the queue holds two of them.
	localparam int SETTLE_CYCLES = 30;
	// Random bytes across all segments; with the directed bytes, the overlong
	// sample and the overshoot of each segment the run sends about 1100 bytes.
	localparam int RANDOM_BYTES = 720;
	localparam int SEGMENTS = 8;

	typedef enum int {
		TEXT_ASCII,
		TEXT_EBCDIC,
		TEXT_MIXED,
		TEXT_BINARY,
		TEXT_NOISE
	} text_flavor_e;

	// Lone bytes that each form a sample of their own: every control class,
	// the edges of the printable range, and EBCDIC bytes, some of which count as both encodings.
	localparam logic [7:0] LONE_BYTES [15] = '{
		8'h00, BYTE_TAB, BYTE_LF, BYTE_E_NL, BYTE_E_HT, 8'h1F, BYTE_SPACE, 8'h7E,
		BYTE_DEL, 8'hFF, BYTE_E_SPACE, BYTE_E_LBRACK, BYTE_E_RBRACK, 8'hC1, 8'h4B
	};

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [PCT_W-1:0] cfg_wdata;

	tedt_sample_if smp();
	tedt_result_if res();

	int fail_count;
	int outstanding;
	int reports_checked;
	int none_verdicts;
	int iso_verdicts;
	int ebcdic_verdicts;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int sender_idle_pct;
	int recv_stall_pct;
	int bytes_sent;
	int samples_sent;
	int settings_used;
	int quiet_cycles;

	text_encoding_detector #(
		.SAMPLE_BYTES(SAMPLE_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.sample(smp),
		.result(res)
	);

	text_encoding_checker #(
		.SAMPLE_BYTES(SAMPLE_BYTES)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.smp(smp),
		.res(res),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.reports_checked(reports_checked),
		.none_verdicts(none_verdicts),
		.iso_verdicts(iso_verdicts),
		.ebcdic_verdicts(ebcdic_verdicts)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// The result side stalls at random, at the rate of the current phase.
	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog: any transfer on either channel proves the block is still alive.
	always @(posedge clk) begin
		if (!arst_n || (smp.valid && smp.ready) || (res.valid && res.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("text_encoding_detector test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Draws one byte of sample text. ASCII text mostly stays printable, EBCDIC
	// text is drawn from its letter, digit and blank codes, binary text is
	// ASCII with stray control bytes, and noise covers every byte value.
	function automatic logic [7:0] draw_byte(input text_flavor_e flavor);
		logic [7:0] b;
		text_flavor_e pick;
		pick = flavor;
		if (flavor == TEXT_MIXED) begin
			pick = ($urandom_range(0, 1) != 0) ? TEXT_ASCII : TEXT_EBCDIC;
		end
		case (pick)
			TEXT_ASCII, TEXT_BINARY: begin
				if ((pick == TEXT_BINARY) && ($urandom_range(0, 7) == 0)) begin
					b = 8'($urandom_range(0, 31));
				end else if ($urandom_range(0, 15) == 0) begin
					b = ($urandom_range(0, 1) != 0) ? BYTE_LF : BYTE_TAB;
				end else begin
					b = 8'($urandom_range(32, 126));
				end
			end
			TEXT_EBCDIC: begin
				case ($urandom_range(0, 7))
					0: b = 8'h81 + 8'($urandom_range(0, 8));
					1: b = 8'h91 + 8'($urandom_range(0, 8));
					2: b = 8'hA2 + 8'($urandom_range(0, 7));
					3: b = 8'hC1 + 8'($urandom_range(0, 8));
					4: b = 8'hD1 + 8'($urandom_range(0, 8));
					5: b = 8'hF0 + 8'($urandom_range(0, 9));
					6: b = BYTE_E_SPACE;
					default: b = ($urandom_range(0, 1) != 0) ? BYTE_E_NL : BYTE_E_HT;
				endcase
			end
			default: b = 8'($urandom_range(0, 255));
		endcase
		return b;
	endfunction

	// Offers one byte and returns once it has been transferred. The valid line
	// is left high so that the next byte can follow in the very next cycle.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ((sender_idle_pct != 0) && ($urandom_range(0, 99) < sender_idle_pct)) begin
			smp.valid <= 1'b0;
			@(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.data_byte <= b;
		smp.last_byte <= last;
		do begin
			@(posedge clk);
		end while (!smp.ready);
		bytes_sent++;
	endtask

	task automatic send_sample(input int len, input text_flavor_e flavor);
		for (int i = 0; i < len; i++) begin
			send_byte(draw_byte(flavor), i == len - 1);
		end
		samples_sent++;
	endtask

	// Stops the sample channel and waits until every expected report has come
	// back, then a little longer so the back end is surely idle.
	task automatic wait_idle();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Both thresholds are written back to back; the enable stays high across the pair.
	task automatic set_thresholds(input logic [PCT_W-1:0] high,
			input logic [PCT_W-1:0] low);
		cfg_wen <= 1'b1;
		cfg_idx <= REG_PCT_HIGH;
		cfg_wdata <= high;
		@(posedge clk);
		cfg_idx <= REG_PCT_LOW;
		cfg_wdata <= low;
		@(posedge clk);
		cfg_wen <= 1'b0;
		settings_used++;
	endtask

	initial begin
		int seg_bytes;
		int len;
		int roll;
		text_flavor_e flavor;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_idx = REG_PCT_HIGH;
		cfg_wdata = '0;
		smp.valid = 1'b0;
		smp.data_byte = '0;
		smp.last_byte = 1'b0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		bytes_sent = 0;
		samples_sent = 0;
		settings_used = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at the reset thresholds and with no idling.
		foreach (LONE_BYTES[i]) begin
			send_byte(LONE_BYTES[i], 1'b1);
			samples_sent++;
		end
		// Plain ASCII letters that no EBCDIC range covers: an ISO-8859-1 verdict.
		send_byte(8'h48, 1'b0);
		send_byte(8'h69, 1'b1);
		// EBCDIC letters only.
		send_byte(8'h81, 1'b0);
		send_byte(8'hC1, 1'b1);
		// A stray control byte in the middle of text: shares still count it.
		send_byte(8'h41, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h42, 1'b1);
		samples_sent += 3;
		// Thresholds above any possible share: nothing can dominate.
		wait_idle();
		set_thresholds(7'd127, 7'd127);
		send_byte(8'h41, 1'b1);
		send_byte(8'hC1, 1'b1);
		samples_sent += 2;

		// Random part: each segment picks an idling phase and a threshold pair,
		// and is entered only once the block has gone quiet.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			wait_idle();
			case (seg % 4)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 79;
					recv_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct = 79;
				end
				default: begin
					sender_idle_pct = 14;
					recv_stall_pct = 14;
				end
			endcase
			case (seg)
				0: set_thresholds(PCT_HIGH_RST, PCT_LOW_RST);
				1: set_thresholds(PCT_FULL, 7'd0);
				2: set_thresholds(7'd0, 7'd127);
				3: set_thresholds(7'd0, 7'd0);
				4: set_thresholds(7'd99, 7'd1);
				default: set_thresholds(7'($urandom_range(0, 127)),
					7'($urandom_range(0, 127)));
			endcase
			// One sample that runs past the sample size, so its tail is ignored
			// while the last mark on it still produces the report.
			if (seg == 1) begin
				send_sample($urandom_range(SAMPLE_BYTES + 1, SAMPLE_BYTES + 40),
					TEXT_ASCII);
			end
			seg_bytes = 0;
			while (seg_bytes < RANDOM_BYTES / SEGMENTS) begin
				roll = $urandom_range(0, 99);
				if (roll < 35) begin
					flavor = TEXT_ASCII;
				end else if (roll < 65) begin
					flavor = TEXT_EBCDIC;
				end else if (roll < 80) begin
					flavor = TEXT_MIXED;
				end else if (roll < 90) begin
					flavor = TEXT_BINARY;
				end else begin
					flavor = TEXT_NOISE;
				end
				if ($urandom_range(0, 99) < 85) begin
					len = $urandom_range(1, 16);
				end else begin
					len = $urandom_range(17, 64);
				end
				send_sample(len, flavor);
				seg_bytes += len;
			end
		end

		sender_idle_pct = 0;
		recv_stall_pct = 0;
		wait_idle();

		$display("Sent %0d bytes in %0d samples under %0d threshold settings, %s %0d.",
			bytes_sent, samples_sent, settings_used, "reports checked:",
			reports_checked);
		$display("Verdicts seen: %0d untagged or binary, %0d ISO-8859-1, %0d EBCDIC.",
			none_verdicts, iso_verdicts, ebcdic_verdicts);
		if (fail_count == 0) begin
			$display("text_encoding_detector test passed");
		end else begin
			$display("text_encoding_detector test failed");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/tedt_pkg.sv
design/tedt_if.sv
design/tedt_front.sv
design/tedt_fifo.sv
design/tedt_back.sv
design/text_encoding_detector.sv
verif/text_encoding_checker.sv
verif/tb_text_encoding_detector.sv
